// ----- rtl/jti_pkg.sv -----
package jti_pkg;

    localparam int MaxPoints = 64;
    localparam int MaxJoints = 8;
    localparam int PtW = $clog2(MaxPoints);
    localparam int JtW = $clog2(MaxJoints);
    localparam int CntW = $clog2(MaxPoints + 1);
    localparam int JcW = $clog2(MaxJoints + 1);
    localparam int PjW = PtW + JtW;
    localparam logic [16:0] OneQ16 = 17'h10000;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_START  = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_CANCEL = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_RUN    = 2'd1,
        MODE_HOLD   = 2'd2,
        MODE_CANCEL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_TRACK   = 2'd0,
        ST_END     = 2'd1,
        ST_INVALID = 2'd2,
        ST_CANCEL  = 2'd3
    } status_t;

    // Handshake between the sequencer and the ratio divider.
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] ratio;
    } div_rsp_t;

endpackage

// ----- rtl/jti_ram.sv -----
module jti_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/jti_div.sv -----
module jti_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  jti_pkg::div_req_t req,
    output jti_pkg::div_rsp_t rsp
);
    import jti_pkg::*;

    // Restoring division, one quotient bit per cycle; num < den so 16 bits suffice.
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [15:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, 1'b0} - {2'b00, den_reg};
        if (req.start) begin
            rem_next  = {1'b0, req.num};
            den_next  = req.den;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[33]) begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end else begin
                rem_next = {rem_reg[31:0], 1'b0};
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.ratio = {1'b0, quo_reg};
endmodule

// ----- rtl/joint_trajectory_interpolator_unit.sv -----
// Joint trajectory interpolator, piecewise linear.
// Input channel (s_valid/s_ready) carries one transaction per request: a load
// writes one point/joint slot, a start arms a goal, a tick asks for targets and
// a cancel freezes the current targets. The result channel (m_valid/m_ready)
// delivers one transaction per joint, joints in order, with m_last on the final
// one. Point times, positions and velocities live in block RAMs with a
// registered read; held targets live in a small register file.
// A tick walks the segment pointer point by point, reading each point's time
// from RAM and comparing it, then, for an interpolated segment, runs a 16-step
// restoring divider for the ratio (skipped when the ratio is 0 or 1), then reads
// the point data of each joint and emits it; a tick in hold or cancel state
// emits the held targets of each joint.
// One request is handled at a time.
// When the receiver stalls, the block waits with the result in the output
// register; nothing is lost. Reset (aresetn low, synchronous) returns the
// block to idle with zero held targets and joint_count 8; point memories are
// not cleared and must be loaded before a start.
module joint_trajectory_interpolator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [5:0]  s_point_index,
    input  logic [2:0]  s_joint_index,
    input  logic [31:0] s_time_from_start,
    input  logic signed [31:0] s_position,
    input  logic signed [31:0] s_velocity,
    input  logic [6:0]  s_point_count,
    input  logic [31:0] s_elapsed_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_joint,
    output logic signed [31:0] m_target_position,
    output logic signed [31:0] m_target_velocity,
    output logic        m_last,
    output logic [1:0]  m_status
);
    import jti_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_WALK  = 9'b000000010,
        S_WCHK  = 9'b000000100,
        S_T1    = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_RDA   = 9'b000100000,
        S_RDB   = 9'b001000000,
        S_CALC  = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    // How the targets of the current tick are formed.
    typedef enum logic [1:0] {
        KIND_INTERP = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_LAST   = 2'd2,
        KIND_HELD   = 2'd3
    } kind_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic [3:0]      jcfg_reg, jcfg_next;
    logic [CntW-1:0] seg_reg, seg_next;
    logic [CntW-1:0] loaded_reg, loaded_next;
    logic [JtW-1:0]  j_reg, j_next;
    logic [JtW:0]    n_reg, n_next;
    logic [31:0]     elapsed_reg, elapsed_next;
    logic [31:0]     t0_reg, t0_next;
    logic [16:0]     ratio_reg, ratio_next;
    kind_t           kind_reg, kind_next;
    logic [1:0]      stat_reg, stat_next;
    logic [31:0]     pa_reg, pa_next, va_reg, va_next;
    logic [31:0]     hp_reg [MaxJoints];
    logic [31:0]     hv_reg [MaxJoints];
    logic            hwe;
    logic [31:0]     hp_w, hv_w;

    logic        mv_reg, mv_next;
    logic [2:0]  mj_reg, mj_next;
    logic [31:0] mp_reg, mp_next, mvl_reg, mvl_next;
    logic        ml_reg, ml_next;
    logic [1:0]  ms_reg, ms_next;

    // Memories.
    logic            t_we, pv_we;
    logic [PtW-1:0]  t_raddr;
    logic [31:0]     t_rdata, p_rdata, v_rdata;
    logic [PjW-1:0]  pv_raddr;
    logic [PjW-1:0]  pv_waddr;

    div_req_t dreq;
    div_rsp_t drsp;

    logic        accept, out_free;
    logic [JtW:0] n_eff;
    logic [32:0]  dt;
    logic [32:0]  num;
    logic signed [33:0] dpos, dvel;
    logic signed [51:0] prodp, prodv;
    logic signed [31:0] rp, rv;
    logic [CntW-1:0] lp;

    assign pv_waddr = {s_point_index, s_joint_index};
    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign t_we     = accept && (req_t'(s_req_type) == REQ_LOAD);
    assign pv_we    = t_we;

    always_comb begin
        if (jcfg_reg == 4'd0) n_eff = (JtW+1)'(1);
        else if (jcfg_reg > 4'(MaxJoints)) n_eff = (JtW+1)'(MaxJoints);
        else n_eff = (JtW+1)'(jcfg_reg);
    end

    jti_ram #(.Width(32), .Depth(MaxPoints)) u_times (
        .aclk(aclk), .we(t_we), .waddr(s_point_index), .wdata(s_time_from_start),
        .raddr(t_raddr), .rdata(t_rdata));
    jti_ram #(.Width(32), .Depth(MaxPoints*MaxJoints)) u_pos (
        .aclk(aclk), .we(pv_we), .waddr(pv_waddr), .wdata(s_position),
        .raddr(pv_raddr), .rdata(p_rdata));
    jti_ram #(.Width(32), .Depth(MaxPoints*MaxJoints)) u_vel (
        .aclk(aclk), .we(pv_we), .waddr(pv_waddr), .wdata(s_velocity),
        .raddr(pv_raddr), .rdata(v_rdata));

    jti_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign lp = loaded_reg - CntW'(1);

    // Interpolation datapath: difference, one multiply each for position and velocity, floor shift.
    assign dpos  = $signed({p_rdata[31], p_rdata}) - $signed({pa_reg[31], pa_reg});
    assign dvel  = $signed({v_rdata[31], v_rdata}) - $signed({va_reg[31], va_reg});
    assign prodp = dpos * $signed({1'b0, ratio_reg});
    assign prodv = dvel * $signed({1'b0, ratio_reg});
    assign rp    = 32'($signed(pa_reg) + 32'(prodp >>> 16));
    assign rv    = 32'($signed(va_reg) + 32'(prodv >>> 16));

    assign dt  = {1'b0, t_rdata} - {1'b0, t0_reg};
    assign num = {1'b0, elapsed_reg} - {1'b0, t0_reg};

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        jcfg_next   = cfg_we ? cfg_wdata : jcfg_reg;
        seg_next    = seg_reg;
        loaded_next = loaded_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        elapsed_next = elapsed_reg;
        t0_next     = t0_reg;
        ratio_next  = ratio_reg;
        kind_next   = kind_reg;
        stat_next   = stat_reg;
        pa_next     = pa_reg;
        va_next     = va_reg;
        mv_next     = mv_reg && !m_ready;
        mj_next     = mj_reg;
        mp_next     = mp_reg;
        mvl_next    = mvl_reg;
        ml_next     = ml_reg;
        ms_next     = ms_reg;
        t_raddr     = seg_reg[PtW-1:0];
        pv_raddr    = {seg_reg[PtW-1:0], j_reg};
        dreq        = '0;
        hwe         = 1'b0;
        hp_w        = rp;
        hv_w        = rv;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (req_t'(s_req_type))
                        REQ_LOAD: begin
                        end
                        REQ_START: begin
                            if (s_point_count == 7'd0) begin
                                mv_next  = 1'b1;
                                mj_next  = '0;
                                mp_next  = '0;
                                mvl_next = '0;
                                ml_next  = 1'b1;
                                ms_next  = ST_INVALID;
                            end else begin
                                loaded_next = (s_point_count > 7'(MaxPoints)) ?
                                              CntW'(MaxPoints) : CntW'(s_point_count);
                                seg_next  = '0;
                                mode_next = MODE_RUN;
                            end
                        end
                        REQ_CANCEL: begin
                            if (mode_reg == MODE_RUN) mode_next = MODE_CANCEL;
                        end
                        REQ_TICK: begin
                            n_next = n_eff;
                            j_next = '0;
                            elapsed_next = s_elapsed_time;
                            if (mode_reg == MODE_HOLD || mode_reg == MODE_CANCEL) begin
                                kind_next  = KIND_HELD;
                                stat_next  = (mode_reg == MODE_HOLD) ? ST_END : ST_CANCEL;
                                state_next = S_EMIT;
                            end else if (mode_reg == MODE_RUN) begin
                                stat_next  = ST_TRACK;
                                state_next = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                // Read time of the current segment pointer.
                if (seg_reg >= loaded_reg) begin
                    kind_next  = KIND_LAST;
                    stat_next  = ST_END;
                    mode_next  = MODE_HOLD;
                    state_next = S_RDB;
                end else begin
                    state_next = S_WCHK;
                end
            end
            S_WCHK: begin
                if (t_rdata < elapsed_reg) begin
                    seg_next   = seg_reg + CntW'(1);
                    state_next = S_WALK;
                end else if (seg_reg == '0) begin
                    kind_next  = KIND_FIRST;
                    state_next = S_RDB;
                end else begin
                    kind_next  = KIND_INTERP;
                    t_raddr    = PtW'(seg_reg - CntW'(1));
                    state_next = S_T1;
                end
            end
            S_T1: begin
                // t_rdata holds t0 here; t_raddr goes back to t1.
                t0_next    = t_rdata;
                state_next = S_DIV;
                ratio_next = '1;
            end
            S_DIV: begin
                if (ratio_reg == '1) begin
                    // t_rdata holds t1 now.
                    if ($signed(dt) <= 33'sd1) begin
                        ratio_next = OneQ16;
                        state_next = S_RDA;
                    end else if ($signed(num) <= 33'sd0) begin
                        ratio_next = '0;
                        state_next = S_RDA;
                    end else if (num >= dt) begin
                        ratio_next = OneQ16;
                        state_next = S_RDA;
                    end else begin
                        dreq.start = 1'b1;
                        dreq.num   = num[31:0];
                        dreq.den   = dt[31:0];
                        ratio_next = 17'h1FFFE;
                    end
                end else if (drsp.done) begin
                    ratio_next = drsp.ratio;
                    state_next = S_RDA;
                end
            end
            S_RDA: begin
                // Issue the read of the segment start for joint j.
                pv_raddr   = {PtW'(seg_reg - CntW'(1)), j_reg};
                state_next = S_RDB;
            end
            S_RDB: begin
                if (kind_reg == KIND_INTERP) begin
                    pa_next = p_rdata;
                    va_next = v_rdata;
                end
                pv_raddr = (kind_reg == KIND_LAST) ? {lp[PtW-1:0], j_reg} :
                           {seg_reg[PtW-1:0], j_reg};
                state_next = S_CALC;
            end
            S_CALC: begin
                hwe = 1'b1;
                if (kind_reg != KIND_INTERP) begin
                    hp_w = p_rdata;
                    hv_w = v_rdata;
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    mv_next  = 1'b1;
                    mj_next  = 3'(j_reg);
                    mp_next  = hp_reg[j_reg];
                    mvl_next = hv_reg[j_reg];
                    ml_next  = ((JtW+1)'(j_reg) + (JtW+1)'(1)) == n_reg;
                    ms_next  = stat_reg;
                    if (ml_next) begin
                        state_next = S_IDLE;
                    end else begin
                        j_next = j_reg + JtW'(1);
                        state_next = (kind_reg == KIND_HELD) ? S_EMIT :
                                     (kind_reg == KIND_INTERP) ? S_RDA : S_RDB;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mode_reg   <= MODE_IDLE;
            jcfg_reg   <= 4'd8;
            seg_reg    <= '0;
            loaded_reg <= '0;
            mv_reg     <= 1'b0;
            for (int i = 0; i < MaxJoints; i++) begin
                hp_reg[i] <= '0;
                hv_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            jcfg_reg   <= jcfg_next;
            seg_reg    <= seg_next;
            loaded_reg <= loaded_next;
            mv_reg     <= mv_next;
            if (hwe) begin
                hp_reg[j_reg] <= hp_w;
                hv_reg[j_reg] <= hv_w;
            end
        end
        j_reg       <= j_next;
        n_reg       <= n_next;
        elapsed_reg <= elapsed_next;
        t0_reg      <= t0_next;
        ratio_reg   <= ratio_next;
        kind_reg    <= kind_next;
        stat_reg    <= stat_next;
        pa_reg      <= pa_next;
        va_reg      <= va_next;
        mj_reg      <= mj_next;
        mp_reg      <= mp_next;
        mvl_reg     <= mvl_next;
        ml_reg      <= ml_next;
        ms_reg      <= ms_next;
    end

    assign m_valid           = mv_reg;
    assign m_out_joint       = mj_reg;
    assign m_target_position = mp_reg;
    assign m_target_velocity = mvl_reg;
    assign m_last            = ml_reg;
    assign m_status          = ms_reg;

`ifndef SYNTHESIS
    // The segment pointer never passes the loaded point count.
    a_seg_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_reg <= loaded_reg) else $error("segment pointer beyond loaded points");
    // Input is only taken while no request is in progress.
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    // A held result is always reported with end status while mode is hold.
    a_hold_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && mode_reg == MODE_HOLD && kind_reg == KIND_HELD)
        |-> stat_reg == ST_END) else $error("hold emits wrong status");
`endif
endmodule
